// File: src/jpeg_frame_dimension_parser_top_assert.svh
// Assertion macros for the JPEG frame dimension parser.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef JPEG_FRAME_DIMENSION_PARSER_TOP_ASSERT_SVH
`define JPEG_FRAME_DIMENSION_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define JFDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jfdp: same-cycle check failed");

// next-cycle implication
`define JFDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jfdp: next-cycle check failed");

`endif

// File: src/jfdp_pkg.sv
// Package for the JPEG frame dimension parser: types, marker codes, defaults.
// No dependencies.
`default_nettype none

package jfdp_pkg;

    localparam logic [7:0]  MARKER_PREFIX       = 8'hFF;
    localparam logic [7:0]  SOF0_CODE           = 8'hC0;
    localparam logic [31:0] DEFAULT_FRAME_LIMIT = 32'd230400;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_FRAME_LIMIT = 1'b0;

    localparam logic [1:0] HDR_LAST_BYTE = 2'd3;

    localparam logic [2:0] OFS_HEIGHT_HI = 3'd4;
    localparam logic [2:0] OFS_HEIGHT_LO = 3'd5;
    localparam logic [2:0] OFS_WIDTH_HI  = 3'd6;
    localparam logic [2:0] OFS_WIDTH_LO  = 3'd7;

    typedef enum logic {
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        SCAN_SEARCHING,
        SCAN_CAPTURING,
        SCAN_DONE
    } scan_t;

    typedef struct packed {
        logic        found;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [31:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

// File: src/jpeg_frame_dimension_parser_top.sv
// JPEG frame dimension parser, top level: header decode, SOF0 scan, result queue.
// Depends on jfdp_pkg and jpeg_frame_dimension_parser_top_assert.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | to block  | in_valid / in_stall     | byte_in
//  out     | from block| out_valid / out_stall   | found, image_width, image_height,
//          |           |                         | frame_length
//  cfg     | to block  | APB psel/penable/pready | paddr, pwdata, prdata (frame_limit)
//
//  One byte per cycle while in_stall is low; a byte is registered, then decoded in the next cycle.
//  A result is taken into the output register, or the skid register, after its last byte is decoded.
//  Results pass through an output register and a skid register.
//  Input stalls when the output, skid and byte registers, less any popped result, hold two or more.
//  Reset clears the parser state and loads the default frame limit.
`default_nettype none
`include "jpeg_frame_dimension_parser_top_assert.svh"

module jpeg_frame_dimension_parser_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    byte_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               found,
    output logic [15:0]                        image_width,
    output logic [15:0]                        image_height,
    output logic [31:0]                        frame_length,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [jfdp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import jfdp_pkg::*;

    logic [31:0] frame_limit_reg;

    logic        pipe_valid_reg;
    logic [7:0]  byte_reg;

    phase_t      phase_reg, phase_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [31:0] length_acc_reg, length_acc_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic        prev_ff_reg, prev_ff_next;
    logic [2:0]  marker_offset_reg, marker_offset_next;
    scan_t       scan_reg, scan_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg, width_next;

    logic        emit;
    logic        emit_found;
    result_t     result;

    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_data_reg, skid_data_next;

    logic        in_accept;
    logic        pop;
    logic [1:0]  occupancy;
    logic        cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_FRAME_LIMIT) ? frame_limit_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_limit_reg <= DEFAULT_FRAME_LIMIT;
        end
        else if (cfg_write && (paddr[2] == REG_FRAME_LIMIT))
        begin
            frame_limit_reg <= pwdata;
        end
    end

    // input handshake
    assign pop       = out_valid_reg && !out_stall;
    assign occupancy = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, pipe_valid_reg};
    assign in_stall  = occupancy > ({1'b0, pop} + 2'd1);
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= byte_in;
        end
    end

    // parser next state
    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        length_acc_next    = length_acc_reg;
        bytes_left_next    = bytes_left_reg;
        prev_ff_next       = prev_ff_reg;
        marker_offset_next = marker_offset_reg;
        scan_next          = scan_reg;
        height_next        = height_reg;
        width_next         = width_reg;
        emit               = 1'b0;
        emit_found         = 1'b0;

        if (pipe_valid_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (header_count_reg == 2'd0)
                    begin
                        length_acc_next = {24'd0, byte_reg};
                    end
                    else
                    begin
                        length_acc_next = length_acc_reg
                                        | ({24'd0, byte_reg} << {header_count_reg, 3'b000});
                    end
                    if (header_count_reg != HDR_LAST_BYTE)
                    begin
                        header_count_next = header_count_reg + 2'd1;
                    end
                    else
                    begin
                        header_count_next  = 2'd0;
                        prev_ff_next       = 1'b0;
                        marker_offset_next = 3'd0;
                        scan_next          = SCAN_SEARCHING;
                        height_next        = 16'd0;
                        width_next         = 16'd0;
                        if ((length_acc_next == 32'd0) || (length_acc_next >= frame_limit_reg))
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            bytes_left_next = length_acc_next;
                            phase_next      = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    unique case (scan_reg)
                        SCAN_SEARCHING:
                        begin
                            if (prev_ff_reg && (byte_reg == SOF0_CODE))
                            begin
                                scan_next          = SCAN_CAPTURING;
                                marker_offset_next = 3'd0;
                            end
                            prev_ff_next = (byte_reg == MARKER_PREFIX);
                        end
                        SCAN_CAPTURING:
                        begin
                            marker_offset_next = marker_offset_reg + 3'd1;
                            unique case (marker_offset_next)
                                OFS_HEIGHT_HI: height_next = {byte_reg, height_reg[7:0]};
                                OFS_HEIGHT_LO: height_next = {height_reg[15:8], byte_reg};
                                OFS_WIDTH_HI:  width_next  = {byte_reg, width_reg[7:0]};
                                OFS_WIDTH_LO:
                                begin
                                    width_next = {width_reg[15:8], byte_reg};
                                    scan_next  = SCAN_DONE;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase

                    if (bytes_left_reg != 32'd0)
                    begin
                        bytes_left_next = bytes_left_reg - 32'd1;
                    end
                    if (bytes_left_next == 32'd0)
                    begin
                        emit              = 1'b1;
                        emit_found        = (scan_next == SCAN_DONE);
                        phase_next        = PH_HEADER;
                        header_count_next = 2'd0;
                    end
                end
                default: ;
            endcase
        end

        result.found        = emit_found;
        result.image_width  = emit_found ? width_next      : 16'd0;
        result.image_height = emit_found ? height_next     : 16'd0;
        result.frame_length = emit_found ? length_acc_next : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= 2'd0;
            length_acc_reg    <= 32'd0;
            bytes_left_reg    <= 32'd0;
            prev_ff_reg       <= 1'b0;
            marker_offset_reg <= 3'd0;
            scan_reg          <= SCAN_SEARCHING;
            height_reg        <= 16'd0;
            width_reg         <= 16'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            length_acc_reg    <= length_acc_next;
            bytes_left_reg    <= bytes_left_next;
            prev_ff_reg       <= prev_ff_next;
            marker_offset_reg <= marker_offset_next;
            scan_reg          <= scan_next;
            height_reg        <= height_next;
            width_reg         <= width_next;
        end
    end

    // output register and skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = emit;
                skid_data_next  = result;
            end
            else
            begin
                out_valid_next = emit;
                out_data_next  = result;
            end
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_data_reg.found;
    assign image_width  = out_data_reg.image_width;
    assign image_height = out_data_reg.image_height;
    assign frame_length = out_data_reg.frame_length;

    `JFDP_ASSERT_NOW(a_skid_behind_head, skid_valid_reg, out_valid_reg)
    `JFDP_ASSERT_NOW(a_no_overflow, emit && out_valid_reg && skid_valid_reg, pop)
    `JFDP_ASSERT_NOW(a_payload_has_bytes, phase_reg == PH_PAYLOAD, bytes_left_reg != 32'd0)
    `JFDP_ASSERT_NOW(a_found_has_length, out_valid_reg && found, frame_length != 32'd0)
    `JFDP_ASSERT_NEXT(a_reject_keeps_header, pipe_valid_reg && phase_reg == PH_HEADER
                      && emit, phase_reg == PH_HEADER)

endmodule

`default_nettype wire
